// ----- rtl/core/olst_pkg.sv -----
// ----------------------------------------------------------------------------
// olst_pkg
// shared types and codes for the ordered list store and its cells
// ----------------------------------------------------------------------------
package olst_pkg;

  // default number of cells
  localparam int DEPTH_DEF = 16;

  // fixed field widths
  localparam int VAL_W = 32;
  localparam int IDX_W = 5;
  localparam int POS_W = 5;

  // request codes
  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_KEY   = 3'd5,
    REQ_SEARCH    = 3'd6,
    REQ_TRAVERSE  = 3'd7
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TRAV
  } state_t;

  // broadcast command to the cell row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic capture;
  } cell_ctl_t;

endpackage

// ----- rtl/core/olst_cell.sv -----
// ----------------------------------------------------------------------------
// olst_cell
// one storage cell of the list row: holds a word, shifts to or from its
// neighbors and registers a key match
// ----------------------------------------------------------------------------
module olst_cell import olst_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [CW-1:0]           at,
  input  logic [CW-1:0]           tail,
  input  logic signed [VAL_W-1:0] load_data,
  input  logic signed [VAL_W-1:0] key,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  input  logic signed [VAL_W-1:0] head_data,
  output logic signed [VAL_W-1:0] data,
  output logic                    match
);

  localparam logic [CW-1:0] POS = CW'(IDX);

  logic signed [VAL_W-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctl.cmd)
      CMD_HOLD: begin
        data_next = data;
      end
      CMD_INSERT: begin
        if (POS > at) begin
          data_next = left_data;
        end else if (POS == at) begin
          data_next = load_data;
        end
      end
      CMD_DELETE: begin
        if (POS >= at) begin
          data_next = right_data;
        end
      end
      CMD_ROTATE: begin
        // circular shift toward the head over the occupied cells
        if (POS == tail) begin
          data_next = head_data;
        end else if (POS < tail) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (ctl.capture) begin
      match <= (data == key);
    end
  end

endmodule

// ----- rtl/core/ordered_list_store.sv -----
// ----------------------------------------------------------------------------
// ordered_list_store
// bounded ordered list of signed words kept in a row of shifting cells
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------
//  request  | req_type, value, index                  | start high, busy low
//  result   | status, position, element, last         | done, one cycle, no hold
//
//  every request but a nonempty traverse is accepted in S_IDLE, which
//  registers the request and each cell's key compare, then S_EXEC does
//  the shift in the cell row and registers the result word
//  a nonempty traverse runs in S_TRAV: one result word per cycle,
//  set by the row rotating one cell toward the head each cycle
//  the result word sits on the ports in the cycle after it is formed, the
//  same cycle in which busy drops, so the next request may overlap it
//  rst clears the element count and the controller; cell contents are
//  not cleared, only cells below count are ever read
//  the receiver cannot stall, so nothing here waits on the output side
//
module ordered_list_store import olst_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              req_type,
  input  logic signed [VAL_W-1:0] value,
  input  logic [IDX_W-1:0]        index,
  output logic                    done,
  output logic [1:0]              status,
  output logic [POS_W-1:0]        position,
  output logic signed [VAL_W-1:0] element,
  output logic                    last
);

  // count needs to hold DEPTH itself
  localparam int CW = $clog2(DEPTH + 1);
  // common width for comparing the request index against count
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // controller state
  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] tcnt, tcnt_next;

  // latched request word
  req_t                    req_q;
  logic signed [VAL_W-1:0] val_q;
  logic [IDX_W-1:0]        idx_q;

  // result word next values
  logic                    done_next;
  status_t                 status_next;
  logic [POS_W-1:0]        position_next;
  logic signed [VAL_W-1:0] element_next;
  logic                    last_next;

  // cell row
  cell_ctl_t               cell_ctl;
  logic [CW-1:0]           at;
  logic [CW-1:0]           tail;
  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]        match_vec;
  logic                    hit_found;
  logic [CW-1:0]           hit_idx;
  logic                    accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign tail   = count - CW'(1);

  // 1-based position, truncated to the port width
  function automatic logic [POS_W-1:0] pos_of(input logic [CW-1:0] p);
    logic [CW+POS_W-1:0] w;
    w = {{POS_W{1'b0}}, p} + (CW+POS_W)'(1);
    return w[POS_W-1:0];
  endfunction

  // first occupied cell whose registered compare hit, lowest index wins
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i] && (CW'(i) < count)) begin
        hit_found = 1'b1;
        hit_idx   = CW'(i);
      end
    end
  end

  // row of cells, each wired to its two neighbors and the head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    olst_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .at         (at),
      .tail       (tail),
      .load_data  (val_q),
      .key        (value),
      .left_data  (left_w),
      .right_data (right_w),
      .head_data  (cell_data[0]),
      .data       (cell_data[g]),
      .match      (match_vec[g])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          // a traverse of a nonempty list streams straight from the row
          if ((req_type == REQ_TRAVERSE) && (count != '0)) begin
            state_next = S_TRAV;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      S_TRAV: begin
        if (tcnt == tail) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // row commands, count update and result word
  always_comb begin
    cell_ctl.cmd     = CMD_HOLD;
    cell_ctl.capture = accept;
    at               = '0;
    count_next       = count;
    tcnt_next        = tcnt;
    done_next        = 1'b0;
    status_next      = ST_OK;
    position_next    = '0;
    element_next     = '0;
    last_next        = 1'b0;

    unique case (state)
      S_IDLE: begin
        tcnt_next = '0;
      end

      S_EXEC: begin
        done_next = 1'b1;
        last_next = 1'b1;
        unique case (req_q)
          REQ_INS_FRONT, REQ_INS_END, REQ_INS_AT: begin
            // full is checked before the index
            if (count == FULL_COUNT) begin
              status_next = ST_FULL;
            end else if ((req_q == REQ_INS_AT) && (XW'(idx_q) > XW'(count))) begin
              status_next = ST_MISS;
            end else begin
              if (req_q == REQ_INS_FRONT) begin
                at = '0;
              end else if (req_q == REQ_INS_END) begin
                at = count;
              end else begin
                at = CW'(idx_q);
              end
              cell_ctl.cmd  = CMD_INSERT;
              count_next    = count + CW'(1);
              position_next = pos_of(at);
            end
          end
          REQ_DEL_FRONT, REQ_DEL_END: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else begin
              at            = (req_q == REQ_DEL_FRONT) ? '0 : tail;
              cell_ctl.cmd  = CMD_DELETE;
              count_next    = count - CW'(1);
              position_next = pos_of(at);
            end
          end
          REQ_DEL_KEY, REQ_SEARCH: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else if (!hit_found) begin
              status_next = ST_MISS;
            end else begin
              at            = hit_idx;
              position_next = pos_of(at);
              if (req_q == REQ_DEL_KEY) begin
                cell_ctl.cmd = CMD_DELETE;
                count_next   = count - CW'(1);
              end
            end
          end
          REQ_TRAVERSE: begin
            // only an empty list reaches here
            status_next = ST_EMPTY;
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end

      S_TRAV: begin
        // head goes out, row rotates, order is back once every occupied cell has gone out
        cell_ctl.cmd  = CMD_ROTATE;
        done_next     = 1'b1;
        element_next  = cell_data[0];
        position_next = pos_of(tcnt);
        last_next     = (tcnt == tail);
        tcnt_next     = tcnt + CW'(1);
      end

      default: begin
        cell_ctl.cmd = CMD_HOLD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      tcnt  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      tcnt  <= tcnt_next;
      done  <= done_next;
    end
  end

  // request latch and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_t'(req_type);
      val_q <= value;
      idx_q <= index;
    end
    status   <= status_next;
    position <= position_next;
    element  <= element_next;
    last     <= last_next;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("element count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1))))
    else $error("element count moved by more than one");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> (($past(state) == S_EXEC) || ($past(state) == S_TRAV)))
    else $error("result word without a working state");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule
